// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers for the rtl files that check themselves
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked later than in ASSERT_NEXT, after an extra delay
`define ASSERT_NEXT2(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

// ===== rtl/kpst_pkg.sv =====
// ----------------------------------------------------------------------------
// kpst_pkg
// shared sizes, codes, types and helper functions of the key and pointer tracker
// ----------------------------------------------------------------------------
package kpst_pkg;

    localparam int NUM_KEYS  = 128;
    localparam int TIME_BITS = 32;
    localparam int KEY_W     = $clog2(NUM_KEYS);

    localparam int CMD_W      = 3;
    localparam int CODE_W     = 7;
    localparam int POS_W      = 16;
    localparam int DELTA_W    = 17;
    localparam int SCROLL_W   = 16;
    localparam int TICK_W     = 16;
    localparam int HOLD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = ((TIME_BITS > TICK_W) ? TIME_BITS : TICK_W) + 1;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 120;

    // command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_KEYDN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KEYUP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    typedef enum logic [1:0] {
        KS_UP       = 2'd0,
        KS_DOWN     = 2'd1,
        KS_PRESSED  = 2'd2,
        KS_RELEASED = 2'd3
    } key_state_t;

    typedef struct packed {
        key_state_t           st;
        logic [TIME_BITS-1:0] hold;
    } key_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LOOKUP,
        ST_EXEC
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_ITEM,
        RD_SWEEP
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic cnt_last;
        logic out_busy;
    } dp_status_t;

    // saturating add of a tick delta to a hold counter
    function automatic logic [TIME_BITS-1:0] hold_add(
        input logic [TIME_BITS-1:0] t,
        input logic [TICK_W-1:0]    delta
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(t) + SUM_W'(delta);
        if (sum > SUM_W'({TIME_BITS{1'b1}})) begin
            return '1;
        end
        return sum[TIME_BITS-1:0];
    endfunction

    // clamp a hold counter to the reported width
    function automatic logic [HOLD_W-1:0] hold_clamp(input logic [TIME_BITS-1:0] t);
        logic [63:0] ext;
        ext = 64'(t);
        if (ext > 64'h0000_0000_FFFF_FFFF) begin
            return '1;
        end
        return ext[HOLD_W-1:0];
    endfunction

endpackage

// ===== rtl/kpst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpst_ctrl
// sequencer: item intake, key table sweep on tick, lookup and result issue
// ----------------------------------------------------------------------------
module kpst_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  kpst_pkg::dp_status_t   dp_status,
    output kpst_pkg::ctrl_cmd_t    ctrl_cmd
);
    import kpst_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctrl_cmd   = '0;
        ctrl_cmd.rd_sel = RD_INPUT;
        case (state_reg)
            ST_IDLE: begin
                // no intake while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    ctrl_cmd.load = 1'b1;
                    if (dp_status.in_tick) begin
                        ctrl_cmd.cnt_clr = 1'b1;
                        state_next = ST_SWEEP;
                    end else begin
                        ctrl_cmd.rd_en = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SWEEP: begin
                ctrl_cmd.rd_en   = 1'b1;
                ctrl_cmd.rd_sel  = RD_SWEEP;
                ctrl_cmd.cnt_inc = 1'b1;
                if (dp_status.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last swept entry is written back here
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                ctrl_cmd.rd_en  = 1'b1;
                ctrl_cmd.rd_sel = RD_ITEM;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!dp_status.out_busy) begin
                    ctrl_cmd.exec = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kpst_dp.sv =====
// ----------------------------------------------------------------------------
// kpst_dp
// key table memory, pointer and scroll registers, sweep update and result register
// ----------------------------------------------------------------------------
module kpst_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kpst_pkg::ctrl_cmd_t               ctrl_cmd,
    output kpst_pkg::dp_status_t              dp_status,
    input  logic [kpst_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [kpst_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kpst_pkg::M_TDATA_W-1:0]    m_tdata
);
    import kpst_pkg::*;

    // held item
    logic [CMD_W-1:0]           cmd_reg;
    logic [CODE_W-1:0]          key_reg;
    logic [POS_W-1:0]           pos_x_reg;
    logic [POS_W-1:0]           pos_y_reg;
    logic signed [SCROLL_W-1:0] scroll_step_reg;
    logic [TICK_W-1:0]          tick_delta_reg;

    // key table
    key_row_t                   key_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]        entry_valid_reg;
    key_row_t                   rd_data_reg;
    logic                       rd_hit_reg;
    logic [KEY_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [KEY_W-1:0]           wr_addr;
    key_row_t                   wr_data;

    // sweep
    logic [KEY_W-1:0]           cnt_reg;
    logic [KEY_W-1:0]           cnt_next;
    logic                       sweep_wr_reg;
    logic [KEY_W-1:0]           sweep_addr_reg;
    key_row_t                   sweep_row;

    // pointer state
    logic [POS_W-1:0]           px_reg, px_next;
    logic [POS_W-1:0]           py_reg, py_next;
    logic signed [DELTA_W-1:0]  dx_reg, dx_next;
    logic signed [DELTA_W-1:0]  dy_reg, dy_next;
    logic signed [SCROLL_W-1:0] scr_reg, scr_next;
    logic signed [SCROLL_W:0]   scr_sum;

    // result
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    key_row_t                   rd_row;
    key_row_t                   new_row;
    logic                       key_ok;
    logic                       key_live;
    logic                       exec_wr;
    logic [STATUS_W-1:0]        status_o;
    logic [HOLD_W-1:0]          hold_o;

    // item intake
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.load) begin
            cmd_reg         <= s_tuser;
            key_reg         <= s_tdata[6:0];
            pos_x_reg       <= s_tdata[22:7];
            pos_y_reg       <= s_tdata[38:23];
            scroll_step_reg <= s_tdata[54:39];
            tick_delta_reg  <= s_tdata[70:55];
        end
    end

    always_comb begin
        case (ctrl_cmd.rd_sel)
            RD_INPUT: rd_addr = KEY_W'(s_tdata[6:0]);
            RD_ITEM:  rd_addr = KEY_W'(key_reg);
            RD_SWEEP: rd_addr = cnt_reg;
            default:  rd_addr = cnt_reg;
        endcase
    end

    // memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (ctrl_cmd.rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
            rd_hit_reg  <= entry_valid_reg[rd_addr];
        end
    end

    // entries never written read as up with zero time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (wr_en) begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_row = rd_hit_reg ? rd_data_reg : key_row_t'('0);

    // sweep counter and registered write-back pipe
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl_cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (ctrl_cmd.cnt_inc) begin
            cnt_next = cnt_reg + KEY_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            sweep_wr_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            sweep_wr_reg <= ctrl_cmd.rd_en && (ctrl_cmd.rd_sel == RD_SWEEP);
        end
    end

    always_ff @(posedge aclk) begin
        sweep_addr_reg <= cnt_reg;
    end

    always_comb begin
        sweep_row = rd_row;
        case (rd_row.st)
            KS_RELEASED: begin
                sweep_row.st   = KS_UP;
                sweep_row.hold = '0;
            end
            KS_DOWN: begin
                sweep_row.st = KS_PRESSED;
            end
            default: begin
            end
        endcase
        if (sweep_row.st == KS_PRESSED) begin
            sweep_row.hold = hold_add(sweep_row.hold, tick_delta_reg);
        end
    end

    // key command update
    assign key_ok   = (32'(key_reg) < 32'(NUM_KEYS));
    assign key_live = key_ok && (key_reg != '0);

    always_comb begin
        new_row = rd_row;
        if (key_live) begin
            case (cmd_reg)
                CMD_KEYDN: begin
                    if (rd_row.st == KS_UP || rd_row.st == KS_RELEASED) begin
                        new_row.st = KS_DOWN;
                    end
                end
                CMD_KEYUP: begin
                    new_row.st = KS_RELEASED;
                end
                default: begin
                end
            endcase
        end
    end

    assign exec_wr = ctrl_cmd.exec && key_live
                     && (cmd_reg == CMD_KEYDN || cmd_reg == CMD_KEYUP);

    assign wr_en   = exec_wr || sweep_wr_reg;
    assign wr_addr = sweep_wr_reg ? sweep_addr_reg : KEY_W'(key_reg);
    assign wr_data = sweep_wr_reg ? sweep_row : new_row;

    // pointer and scroll
    assign scr_sum = {scr_reg[SCROLL_W-1], scr_reg}
                     + {scroll_step_reg[SCROLL_W-1], scroll_step_reg};

    always_comb begin
        px_next  = px_reg;
        py_next  = py_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        scr_next = scr_reg;
        if (ctrl_cmd.exec) begin
            case (cmd_reg)
                CMD_MOVE: begin
                    px_next = pos_x_reg;
                    py_next = pos_y_reg;
                    dx_next = {1'b0, pos_x_reg} - {1'b0, px_reg};
                    dy_next = {1'b0, pos_y_reg} - {1'b0, py_reg};
                end
                CMD_SCROLL: begin
                    if (scr_sum[SCROLL_W] != scr_sum[SCROLL_W-1]) begin
                        scr_next = scr_sum[SCROLL_W] ? {1'b1, {(SCROLL_W-1){1'b0}}}
                                                     : {1'b0, {(SCROLL_W-1){1'b1}}};
                    end else begin
                        scr_next = scr_sum[SCROLL_W-1:0];
                    end
                end
                CMD_TICK: begin
                    dx_next  = '0;
                    dy_next  = '0;
                    scr_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg  <= '0;
            py_reg  <= '0;
            dx_reg  <= '0;
            dy_reg  <= '0;
            scr_reg <= '0;
        end else begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            scr_reg <= scr_next;
        end
    end

    // result register
    assign status_o = key_ok ? new_row.st : KS_UP;
    assign hold_o   = key_ok ? hold_clamp(new_row.hold) : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (ctrl_cmd.exec) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({scr_next, dy_next, dx_next, py_next, px_next,
                                        hold_o, status_o});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign dp_status.in_tick  = (s_tuser == CMD_TICK);
    assign dp_status.cnt_last = (cnt_reg == KEY_W'(NUM_KEYS - 1));
    assign dp_status.out_busy = m_tvalid_reg && !m_tready;

endmodule

// ===== rtl/key_and_pointer_state_tracker.sv =====
// ----------------------------------------------------------------------------
// key_and_pointer_state_tracker
// per-key state and hold time tracking with pointer position, delta and scroll
// ----------------------------------------------------------------------------
// every accepted word returns exactly one result word describing the named key
// and the pointer after the update; key down, key up, pointer move, scroll and
// unknown commands take a key table read, then an update and write-back step
// that waits while the output register is stalled; a frame tick first sweeps
// the key table one entry per cycle, writing each entry back as the next is
// read, before the named key is looked up; a new word is taken while the
// previous result still waits in the output register; per-key valid flags
// make the table read as all keys up right out of reset, with no clearing pass
`include "assert_macros.svh"

module key_and_pointer_state_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_code[6:0], pos_x[22:7], pos_y[38:23], scroll_step[54:39],
    // tick_delta[70:55], zero pad[71]
    input  logic [kpst_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[2:0]
    input  logic [kpst_pkg::CMD_W-1:0]        s_tuser,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // key_status[1:0], hold_time[33:2], cur_x[49:34], cur_y[65:50],
    // move_dx[82:66], move_dy[99:83], scroll_sum[115:100], zero pad[119:116]
    output logic [kpst_pkg::M_TDATA_W-1:0]    m_tdata
);
    import kpst_pkg::*;

    // command and status bundles between sequencer and datapath
    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // sequencer: intake, tick sweep, lookup, result issue
    kpst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // datapath: key table, pointer registers, output register
    kpst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a result is never loaded over one that is still waiting
    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, ctrl_cmd.exec, !(m_tvalid && !m_tready), "result overwritten while stalled")

    // a tick word blocks intake while the table is swept
    `ASSERT_NEXT(a_tick_blocks, aclk, aresetn, s_tvalid && s_tready && (s_tuser == CMD_TICK), !s_tready, "word accepted during tick sweep")

    // a non-tick word into an empty output has its result loaded by the update step without a stall
    `ASSERT_NEXT2(a_short_latency, aclk, aresetn, s_tvalid && s_tready && (s_tuser != CMD_TICK) && !m_tvalid, m_tvalid, "key or pointer result late")

endmodule

// ===== test/tb_key_and_pointer_state_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_and_pointer_state_tracker
// self-checking bench: a directed table of corner words, then weighted random
// key, pointer, scroll and tick traffic, with every result word compared
// against an in-bench tracker model while both stream sides idle at random
// ----------------------------------------------------------------------------
module tb_key_and_pointer_state_tracker;

    import kpst_pkg::*;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int DIR_ROWS     = 25;
    localparam int RAND_WORDS   = 750;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // a tick sweeps every key before the result, so it bounds the latency
    localparam int TAIL_CYCLES  = NUM_KEYS + 16;
    localparam int MAX_IDLE     = 17;

    // one input word, split into its fields
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CODE_W-1:0]   key;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [SCROLL_W-1:0] scroll_step;
        logic [TICK_W-1:0]   tick_delta;
    } event_t;

    // one result word, split into its fields
    typedef struct packed {
        key_state_t          key_status;
        logic [HOLD_W-1:0]   hold_time;
        logic [POS_W-1:0]    cur_x;
        logic [POS_W-1:0]    cur_y;
        logic [DELTA_W-1:0]  move_dx;
        logic [DELTA_W-1:0]  move_dy;
        logic [SCROLL_W-1:0] scroll_sum;
    } report_t;

    // directed row: input word, plus a hand-written report where it is obvious
    typedef struct packed {
        event_t  ev;
        logic    fixed;
        report_t rep;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // tracker model state
    key_state_t             key_state_tab [NUM_KEYS];
    logic [TIME_BITS-1:0]   hold_tab [NUM_KEYS];
    logic [POS_W-1:0]       ptr_x;
    logic [POS_W-1:0]       ptr_y;
    logic [DELTA_W-1:0]     ptr_dx;
    logic [DELTA_W-1:0]     ptr_dy;
    logic [SCROLL_W-1:0]    scroll_total;

    report_t                pending_reports [$];
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     words_seen = 0;

    // corner words; fixed reports only right after reset
    dir_row_t directed_rows [DIR_ROWS] = '{
        // null key down out of reset: nothing moves
        '{'{CMD_KEYDN,    7'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{KS_UP,   32'h0000_0000, 16'h0, 16'h0, 17'h0, 17'h0, 16'h0}},
        // highest key goes down
        '{'{CMD_KEYDN,    7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{KS_DOWN, 32'h0000_0000, 16'h0, 16'h0, 17'h0, 17'h0, 16'h0}},
        // largest tick: down becomes pressed and takes the full delta
        '{'{CMD_TICK,     7'd127, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
          '{KS_PRESSED, 32'h0000_FFFF, 16'h0, 16'h0, 17'h0, 17'h0, 16'h0}},
        // repeated key down on a pressed key
        '{'{CMD_KEYDN,    7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // pointer to the far corner and back: largest positive and negative change
        '{'{CMD_MOVE,     7'd127, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_MOVE,     7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_MOVE,     7'd1,   16'h1234, 16'h8000, 16'h5A5A, 16'hA5A5}, 1'b0, '0},
        // scroll up to the positive bound, then past it
        '{'{CMD_SCROLL,   7'd1,   16'h0000, 16'h0000, 16'h7FFF, 16'h0000}, 1'b0, '0},
        '{'{CMD_SCROLL,   7'd1,   16'h0000, 16'h0000, 16'h0001, 16'h0000}, 1'b0, '0},
        // zero tick clears the pointer change and the scroll sum only
        '{'{CMD_TICK,     7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // scroll down to the negative bound, then past it
        '{'{CMD_SCROLL,   7'd1,   16'h0000, 16'h0000, 16'h8000, 16'h0000}, 1'b0, '0},
        '{'{CMD_SCROLL,   7'd1,   16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        // key up on a pressed key keeps its hold time until the next tick
        '{'{CMD_KEYUP,    7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // null key up
        '{'{CMD_KEYUP,    7'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // key down on a released key
        '{'{CMD_KEYDN,    7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // key up on a key that was up
        '{'{CMD_KEYUP,    7'd5,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{CMD_KEYDN,    7'd64,  16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // released key returns to up with its time cleared
        '{'{CMD_TICK,     7'd5,   16'h0000, 16'h0000, 16'h0000, 16'h0001}, 1'b0, '0},
        '{'{CMD_TICK,     7'd127, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_KEYUP,    7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        // unused commands change nothing but still report
        '{'{CMD_RSVD_5,   7'd127, 16'hAAAA, 16'h5555, 16'h7FFF, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_RSVD_6,   7'd64,  16'h5555, 16'hAAAA, 16'h8000, 16'h0001}, 1'b0, '0},
        '{'{CMD_RSVD_7,   7'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{CMD_TICK,     7'd127, 16'h0000, 16'h0000, 16'h0000, 16'h1234}, 1'b0, '0},
        // other fields set but ignored on a key down
        '{'{CMD_KEYDN,    7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };

    key_and_pointer_state_tracker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // applies one accepted word to the model and returns the report it causes
    function automatic report_t track_event(input event_t ev);
        report_t          rep;
        logic [16:0]      scroll_wide;
        logic [TIME_BITS:0] hold_wide;
        case (ev.cmd)
            CMD_KEYDN: begin
                if (ev.key != 0 && (key_state_tab[ev.key] == KS_UP ||
                                    key_state_tab[ev.key] == KS_RELEASED)) begin
                    key_state_tab[ev.key] = KS_DOWN;
                end
            end
            CMD_KEYUP: begin
                if (ev.key != 0) begin
                    key_state_tab[ev.key] = KS_RELEASED;
                end
            end
            CMD_MOVE: begin
                // 17-bit wrap gives the exact signed difference
                ptr_dx = {1'b0, ev.pos_x} - {1'b0, ptr_x};
                ptr_dy = {1'b0, ev.pos_y} - {1'b0, ptr_y};
                ptr_x  = ev.pos_x;
                ptr_y  = ev.pos_y;
            end
            CMD_SCROLL: begin
                scroll_wide = {scroll_total[15], scroll_total} +
                              {ev.scroll_step[15], ev.scroll_step};
                // top two bits disagree on overflow past either bound
                if (!scroll_wide[16] && scroll_wide[15]) begin
                    scroll_total = 16'h7FFF;
                end else if (scroll_wide[16] && !scroll_wide[15]) begin
                    scroll_total = 16'h8000;
                end else begin
                    scroll_total = scroll_wide[15:0];
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (key_state_tab[i] == KS_RELEASED) begin
                        key_state_tab[i] = KS_UP;
                        hold_tab[i] = '0;
                    end else if (key_state_tab[i] == KS_DOWN) begin
                        key_state_tab[i] = KS_PRESSED;
                    end
                    if (key_state_tab[i] == KS_PRESSED) begin
                        hold_wide = {1'b0, hold_tab[i]} + ev.tick_delta;
                        hold_tab[i] = hold_wide[TIME_BITS] ? '1 : hold_wide[TIME_BITS-1:0];
                    end
                end
                ptr_dx = '0;
                ptr_dy = '0;
                scroll_total = '0;
            end
            default: begin
            end
        endcase
        rep.key_status = key_state_tab[ev.key];
        rep.hold_time  = hold_tab[ev.key];
        rep.cur_x      = ptr_x;
        rep.cur_y      = ptr_y;
        rep.move_dx    = ptr_dx;
        rep.move_dy    = ptr_dy;
        rep.scroll_sum = scroll_total;
        return rep;
    endfunction

    // drives one word after a random gap, unless no_gaps is set, and waits for the handshake
    task automatic send_word(input event_t ev, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.cmd;
        s_tdata  <= {1'b0, ev.tick_delta, ev.scroll_step, ev.pos_y, ev.pos_x, ev.key};
        do @(posedge aclk); while (!s_tready);
    endtask

    // holds the sender until every outstanding report has come back
    task automatic wait_drained;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // stimulus: reset, directed table, random traffic, drain
    initial begin
        event_t  ev;
        report_t rep;
        int      pick;
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_state_tab[i] = KS_UP;
            hold_tab[i] = '0;
        end
        ptr_x = '0;
        ptr_y = '0;
        ptr_dx = '0;
        ptr_dy = '0;
        scroll_total = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(directed_rows[r].ev, 1'b0);
            rep = track_event(directed_rows[r].ev);
            pending_reports.push_back(directed_rows[r].fixed ? directed_rows[r].rep : rep);
        end

        // sender pause until the directed part has fully drained
        s_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RAND_WORDS; n++) begin
            // mostly a few hot keys so their state machines get exercised
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                ev.cmd = CMD_KEYDN;
            end else if (pick < 52) begin
                ev.cmd = CMD_KEYUP;
            end else if (pick < 64) begin
                ev.cmd = CMD_MOVE;
            end else if (pick < 78) begin
                ev.cmd = CMD_SCROLL;
            end else if (pick < 92) begin
                ev.cmd = CMD_TICK;
            end else begin
                ev.cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            end
            ev.key = ($urandom_range(0, 99) < 70) ? CODE_W'($urandom_range(1, 6))
                                                  : CODE_W'($urandom_range(0, 127));
            ev.pos_x       = POS_W'($urandom);
            ev.pos_y       = POS_W'($urandom);
            // small steps let the sum wander, large ones slam into the bounds
            ev.scroll_step = ($urandom_range(0, 1) == 1) ? SCROLL_W'($urandom)
                                                         : SCROLL_W'($urandom_range(0, 511) - 256);
            ev.tick_delta  = TICK_W'($urandom);
            // every third block of words runs back to back
            send_word(ev, ((n / 48) % 3) == 1);
            pending_reports.push_back(track_event(ev));
            if (n == RAND_WORDS / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side back-pressure; every third block of words never stalls
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = (((words_seen / 40) % 3) == 2) ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // compares each accepted result word with the oldest outstanding report
    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_reports.size() == 0) begin
                $error("result word with no outstanding report: %0h", m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("key_status", 32'(want.key_status), 32'(m_tdata[1:0]));
                check_field("hold_time",  want.hold_time,        m_tdata[33:2]);
                check_field("cur_x",      32'(want.cur_x),       32'(m_tdata[49:34]));
                check_field("cur_y",      32'(want.cur_y),       32'(m_tdata[65:50]));
                check_field("move_dx",    32'(want.move_dx),     32'(m_tdata[82:66]));
                check_field("move_dy",    32'(want.move_dy),     32'(m_tdata[99:83]));
                check_field("scroll_sum", 32'(want.scroll_sum),  32'(m_tdata[115:100]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
